[hdl/modular_inverse_ext_euclid_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef MODULAR_INVERSE_EXT_EUCLID_CORE_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MIE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/mie_pkg.sv]
`default_nettype none

package mie_pkg;

    localparam int FIELD_BITS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK_N,
        ST_DIV_INIT,
        ST_UPD_INIT,
        ST_CHECK_R,
        ST_DIV_LOOP,
        ST_UPD_LOOP,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture operands
        logic div_init;  // start value / modulus
        logic div_loop;  // start r0 / r1
        logic div_step;  // one quotient bit
        logic upd_init;  // seed remainders and coefficients
        logic upd_loop;  // one Euclid update
        logic finish;    // load output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic n_zero;
        logic r1_zero;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/mie_datapath.sv]
`default_nettype none

module mie_datapath
    import mie_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                  clk,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire logic [FIELD_BITS-1:0] value,
    input  wire logic [FIELD_BITS-1:0] modulus,
    output logic                       found,
    output logic [FIELD_BITS-1:0]      inverse,
    output logic [FIELD_BITS-1:0]      divisor
);

    localparam int W        = WORD_BITS;
    localparam int IN_BITS  = (W < FIELD_BITS) ? W : FIELD_BITS;
    localparam int CNT_BITS = $clog2(W);

    logic [W-1:0]        a_reg, n_reg;
    logic [W-1:0]        r0_reg, r1_reg;
    logic [W-1:0]        t0_reg, t1_reg;   // coefficient magnitudes
    logic                neg0_reg, neg1_reg;
    logic [W-1:0]        rem_reg, dvd_reg, dsr_reg, prod_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    logic                found_reg;
    logic [W-1:0]        inv_reg, gcd_reg;

    // restoring division step, quotient times t1 built alongside
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         qbit;
    logic [W-1:0] rem_step;
    logic [W-1:0] prod_step;

    // result forming
    logic         n_zero;
    logic [W-1:0] t_red;
    logic         found_c;
    logic [W-1:0] inv_c;
    logic [W-1:0] gcd_c;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        qbit      = ~diff[W];
        rem_step  = qbit ? diff[W-1:0] : shifted[W-1:0];
        prod_step = {prod_reg[W-2:0], 1'b0} + (qbit ? t1_reg : '0);
    end

    always_comb
    begin
        n_zero  = (n_reg == '0);
        // t0 never exceeds n, so one subtract reduces it
        t_red   = (t0_reg >= n_reg) ? (t0_reg - n_reg) : t0_reg;
        found_c = ~n_zero && (r0_reg == W'(1));
        if (!found_c)
        begin
            inv_c = '0;
        end
        else if (neg0_reg && (t_red != '0))
        begin
            inv_c = n_reg - t_red;
        end
        else
        begin
            inv_c = t_red;
        end
        gcd_c = n_zero ? a_reg : r0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= W'(value[IN_BITS-1:0]);
            n_reg <= W'(modulus[IN_BITS-1:0]);
        end
        else if (cmd.div_init || cmd.div_loop)
        begin
            rem_reg  <= '0;
            prod_reg <= '0;
            cnt_reg  <= '0;
            dvd_reg  <= cmd.div_init ? a_reg : r0_reg;
            dsr_reg  <= cmd.div_init ? n_reg : r1_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_step;
            prod_reg <= prod_step;
            dvd_reg  <= {dvd_reg[W-2:0], 1'b0};
            cnt_reg  <= cnt_reg + 1'b1;
        end
        else if (cmd.upd_init)
        begin
            r0_reg   <= n_reg;
            r1_reg   <= rem_reg;
            t0_reg   <= '0;
            t1_reg   <= W'(1);
            neg0_reg <= 1'b0;
            neg1_reg <= 1'b0;
        end
        else if (cmd.upd_loop)
        begin
            r0_reg   <= r1_reg;
            r1_reg   <= rem_reg;
            t0_reg   <= t1_reg;
            t1_reg   <= t0_reg + prod_reg;
            neg0_reg <= neg1_reg;
            neg1_reg <= ~neg1_reg;
        end

        if (cmd.finish)
        begin
            found_reg <= found_c;
            inv_reg   <= inv_c;
            gcd_reg   <= gcd_c;
        end
    end

    always_comb
    begin
        status.n_zero   = n_zero;
        status.r1_zero  = (r1_reg == '0);
        status.div_last = (cnt_reg == CNT_BITS'(W - 1));
    end

    assign found   = found_reg;
    assign inverse = FIELD_BITS'(inv_reg);
    assign divisor = FIELD_BITS'(gcd_reg);

endmodule

`default_nettype wire

[hdl/mie_ctrl.sv]
`default_nettype none

module mie_ctrl
    import mie_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK_N;
                end
            end
            ST_CHECK_N:
            begin
                if (status.n_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_UPD_INIT;
                end
            end
            ST_UPD_INIT:
            begin
                cmd.upd_init = 1'b1;
                state_next   = ST_CHECK_R;
            end
            ST_CHECK_R:
            begin
                if (status.r1_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_loop = 1'b1;
                    state_next   = ST_DIV_LOOP;
                end
            end
            ST_DIV_LOOP:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_UPD_LOOP;
                end
            end
            ST_UPD_LOOP:
            begin
                cmd.upd_loop = 1'b1;
                state_next   = ST_CHECK_R;
            end
            ST_FINISH:
            begin
                // wait for the output register to be free
                if (!m_valid_reg || m_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

[hdl/modular_inverse_ext_euclid_core.sv]
// Channel | Dir | Signals                    | Contents (lowest bit first)
// s       | in  | s_tvalid s_tready s_tdata  | value[31:0], modulus[31:0]
// m       | out | m_tvalid m_tready m_tdata  | inverse[31:0], divisor[31:0]
//         |     | m_tuser                    | found
//
// A transaction loads the operands, checks the modulus, divides the value by
// the modulus, then runs Euclid steps (division plus update) until r1 is zero.
// Each step is bounded by the bit-serial divider: one quotient bit per cycle.
// A zero modulus skips the divider and goes from the modulus check to the finish state.
// Reset is asynchronous, active low; no clearing pass is needed.
// A finished result waits in the output register; the next transaction is
// accepted while it waits, and only the final write stalls on m_tready.
`default_nettype none

module modular_inverse_ext_euclid_core
    import mie_pkg::*;
#(
    parameter int WORD_BITS = 32     // internal operand width, 8..64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // input transaction
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [2*FIELD_BITS-1:0] s_tdata,   // value, modulus
    // result transaction
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [2*FIELD_BITS-1:0]      m_tdata,   // inverse, divisor
    output logic [0:0]                   m_tuser    // found
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    logic                  found;
    logic [FIELD_BITS-1:0] inverse;
    logic [FIELD_BITS-1:0] divisor;

    // sequencer: operand load, divisions, coefficient updates, output write
    mie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // remainders, signed coefficients, shared divider, output register
    mie_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .status  (status),
        .value   (s_tdata[FIELD_BITS-1:0]),
        .modulus (s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
        .found   (found),
        .inverse (inverse),
        .divisor (divisor)
    );

    assign m_tdata = {divisor, inverse};
    assign m_tuser = found;

endmodule

`default_nettype wire

[hdl/mie_checker.sv]
`default_nettype none
`include "modular_inverse_ext_euclid_core_macros.svh"

module mie_checker
    import mie_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    m_tvalid,
    input wire logic                    m_tready,
    input wire logic [2*FIELD_BITS-1:0] m_tdata,
    input wire logic [0:0]              m_tuser
);

    // a stalled result stays offered
    `MIE_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // and does not change
    `MIE_ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tuser))

    // no inverse reported without found
    `MIE_ASSERT_IMPLIES(a_inv_zero, clk, rst_n, m_tvalid && !m_tuser[0],
        m_tdata[FIELD_BITS-1:0] == '0)

    // found only with gcd one
    `MIE_ASSERT_IMPLIES(a_gcd_one, clk, rst_n, m_tvalid && m_tuser[0],
        m_tdata[2*FIELD_BITS-1:FIELD_BITS] == FIELD_BITS'(1))

endmodule

bind modular_inverse_ext_euclid_core mie_checker u_mie_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
